>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL of the convolution block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define NKC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define NKC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/nkc_pkg.sv
// ----------------------------------------------------------------------------
// nkc_pkg
// Shared constants and types of the normalized kernel convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package nkc_pkg;

  localparam int MAX_WIDTH       = 256;
  localparam int MAX_HEIGHT      = 256;
  localparam int MAX_KERNEL_SIDE = 15;
  localparam int WEIGHT_DEPTH    = 256;
  localparam int PIXEL_MAX       = 255;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W    = 9;
  localparam int SIDE_W   = 4;
  localparam int TAP_W    = $clog2(WEIGHT_DEPTH);
  localparam int PIXEL_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int PROD_W   = WEIGHT_W + PIXEL_W + 1;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int WSUM_W   = WEIGHT_W + TAP_W;
  // signed window coordinates: position minus half side plus tap offset
  localparam int COORD_W  = ROW_W + 3;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE     = 2'd2;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_WIDTH  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_HEIGHT = 2'd3;

  localparam logic [DIM_W-1:0]  RESET_IMAGE_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0]  RESET_IMAGE_HEIGHT = 9'd256;
  localparam logic [SIDE_W-1:0] RESET_KERNEL_SIDE  = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_DIV,
    ST_OUT
  } nkc_state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } nkc_mac_ctrl_t;

endpackage

`default_nettype wire

>>> sv/nkc_ram.sv
// ----------------------------------------------------------------------------
// nkc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/nkc_mac.sv
// ----------------------------------------------------------------------------
// nkc_mac
// Two-stage multiply-accumulate: weighted pixel sum and weight sum.
// ----------------------------------------------------------------------------
`default_nettype none

module nkc_mac (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire nkc_pkg::nkc_mac_ctrl_t             ctrl,
  input  wire logic [nkc_pkg::PIXEL_W-1:0]        pixel,
  input  wire logic signed [nkc_pkg::WEIGHT_W-1:0] weight,
  output logic                                    prod_valid,
  output logic signed [nkc_pkg::ACC_W-1:0]        acc,
  output logic signed [nkc_pkg::WSUM_W-1:0]       wsum
);

  logic signed [nkc_pkg::PROD_W-1:0]   prod;
  logic signed [nkc_pkg::WEIGHT_W-1:0] weight_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.valid & ~ctrl.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.valid) begin
      prod     <= $signed({1'b0, pixel}) * weight;
      weight_d <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc  <= '0;
      wsum <= '0;
    end else if (prod_valid) begin
      acc  <= acc + {{(nkc_pkg::ACC_W-nkc_pkg::PROD_W){prod[nkc_pkg::PROD_W-1]}}, prod};
      wsum <= wsum
            + {{(nkc_pkg::WSUM_W-nkc_pkg::WEIGHT_W){weight_d[nkc_pkg::WEIGHT_W-1]}}, weight_d};
    end
  end

endmodule

`default_nettype wire

>>> sv/nkc_div.sv
// ----------------------------------------------------------------------------
// nkc_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nkc_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [nkc_pkg::ACC_W-1:0]   dividend,
  input  wire logic [nkc_pkg::WSUM_W-1:0]  divisor,
  output logic                             done,
  output logic [nkc_pkg::ACC_W-1:0]        quotient
);

  localparam int N     = nkc_pkg::ACC_W;
  localparam int D     = nkc_pkg::WSUM_W;
  localparam int CNT_W = $clog2(N);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [D-1:0]     rem;
  logic [D-1:0]     dvs;
  logic [D:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem, quotient[N-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == CNT_W'(N - 1));
      if (start) begin
        active <= 1'b1;
      end else if (active && (cnt == CNT_W'(N - 1))) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt      <= '0;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (active) begin
      cnt <= cnt + 1'b1;
      if (fits) begin
        rem      <= D'(rem_sh - {1'b0, dvs});
        quotient <= {quotient[N-2:0], 1'b1};
      end else begin
        rem      <= rem_sh[D-1:0];
        quotient <= {quotient[N-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/normalized_kernel_convolution.sv
// ----------------------------------------------------------------------------
// normalized_kernel_convolution
// 2D convolution with a loadable signed kernel, normalized by the weight sum.
// ----------------------------------------------------------------------------
// Weight loads and pixel writes go straight into memory; busy stays low for them.
// A compute item walks the kernel taps with one frame read per tap, then drains the
// multiply-accumulate pipe and runs the bit-serial divider, which is skipped when the
// weights sum to zero (an empty kernel reads no taps); then done is raised. One item at a time.
// Synchronous reset clears the control state and sets the registers to 256, 256, 3, 3;
// the memories hold no reset value. done is a one-cycle strobe; it cannot be stalled.
`default_nettype none
`include "assert_macros.svh"

module normalized_kernel_convolution (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic [nkc_pkg::KIND_W-1:0]           kind,
  input  wire logic [nkc_pkg::TAP_W-1:0]            tap_index,
  input  wire logic signed [nkc_pkg::WEIGHT_W-1:0]  weight_value,
  input  wire logic [nkc_pkg::ROW_W-1:0]            row,
  input  wire logic [nkc_pkg::COL_W-1:0]            column,
  input  wire logic [nkc_pkg::PIXEL_W-1:0]          pixel_in,
  input  wire logic                                 cfg_we,
  input  wire logic [nkc_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [nkc_pkg::DIM_W-1:0]            cfg_data,
  output logic                                      done,
  output logic [nkc_pkg::ROW_W-1:0]                 out_row,
  output logic [nkc_pkg::COL_W-1:0]                 out_column,
  output logic [nkc_pkg::PIXEL_W-1:0]               out_pixel
);

  localparam int CW = nkc_pkg::COORD_W;

  nkc_pkg::nkc_state_t state, state_next;

  logic [nkc_pkg::DIM_W-1:0]  image_width;
  logic [nkc_pkg::DIM_W-1:0]  image_height;
  logic [nkc_pkg::SIDE_W-1:0] kernel_width;
  logic [nkc_pkg::SIDE_W-1:0] kernel_height;

  logic [nkc_pkg::DIM_W-1:0]  w_eff, h_eff;
  logic [nkc_pkg::SIDE_W-1:0] kw_eff, kh_eff;

  logic accept, accept_compute, empty_kernel;

  logic [nkc_pkg::SIDE_W-1:0] ki, kj;
  logic [nkc_pkg::TAP_W-1:0]  tap;
  logic signed [CW-1:0]       base_r, base_c;
  logic signed [CW-1:0]       ys, xs;
  logic [nkc_pkg::ROW_W-1:0]  yi;
  logic [nkc_pkg::COL_W-1:0]  xi;
  logic                       issue, last_tap, rd_valid;

  logic [nkc_pkg::PIXEL_W-1:0]         frame_rdata;
  logic [nkc_pkg::WEIGHT_W-1:0]        weight_rdata;
  nkc_pkg::nkc_mac_ctrl_t              mac_ctrl;
  logic                                prod_valid;
  logic signed [nkc_pkg::ACC_W-1:0]    acc;
  logic signed [nkc_pkg::WSUM_W-1:0]   wsum;
  logic                                pipe_idle;

  logic [nkc_pkg::ACC_W-1:0]  acc_mag;
  logic [nkc_pkg::WSUM_W-1:0] wsum_mag;
  logic                       wsum_zero, div_start, div_done;
  logic [nkc_pkg::ACC_W-1:0]  quotient;
  logic                       pix_load;
  logic [nkc_pkg::PIXEL_W-1:0] pix_value;

  function automatic logic [nkc_pkg::PIXEL_W-1:0] sat_pixel(
    input logic                      neg,
    input logic [nkc_pkg::ACC_W-1:0] mag
  );
    logic [nkc_pkg::PIXEL_W-1:0] r;
    if (neg) begin
      r = '0;
    end else if (mag > nkc_pkg::ACC_W'(nkc_pkg::PIXEL_MAX)) begin
      r = nkc_pkg::PIXEL_W'(nkc_pkg::PIXEL_MAX);
    end else begin
      r = mag[nkc_pkg::PIXEL_W-1:0];
    end
    return r;
  endfunction

  // ---- configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= nkc_pkg::RESET_IMAGE_WIDTH;
      image_height  <= nkc_pkg::RESET_IMAGE_HEIGHT;
      kernel_width  <= nkc_pkg::RESET_KERNEL_SIDE;
      kernel_height <= nkc_pkg::RESET_KERNEL_SIDE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nkc_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        nkc_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        nkc_pkg::REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[nkc_pkg::SIDE_W-1:0];
        nkc_pkg::REG_KERNEL_HEIGHT: kernel_height <= cfg_data[nkc_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero image size acts as one and an oversize one saturates; kernel sides clamp to 15
  always_comb begin
    priority if (image_width == '0) w_eff = nkc_pkg::DIM_W'(1);
    else if (image_width > nkc_pkg::DIM_W'(nkc_pkg::MAX_WIDTH))
      w_eff = nkc_pkg::DIM_W'(nkc_pkg::MAX_WIDTH);
    else w_eff = image_width;
    priority if (image_height == '0) h_eff = nkc_pkg::DIM_W'(1);
    else if (image_height > nkc_pkg::DIM_W'(nkc_pkg::MAX_HEIGHT))
      h_eff = nkc_pkg::DIM_W'(nkc_pkg::MAX_HEIGHT);
    else h_eff = image_height;
    kw_eff = (kernel_width > nkc_pkg::SIDE_W'(nkc_pkg::MAX_KERNEL_SIDE))
           ? nkc_pkg::SIDE_W'(nkc_pkg::MAX_KERNEL_SIDE) : kernel_width;
    kh_eff = (kernel_height > nkc_pkg::SIDE_W'(nkc_pkg::MAX_KERNEL_SIDE))
           ? nkc_pkg::SIDE_W'(nkc_pkg::MAX_KERNEL_SIDE) : kernel_height;
  end

  assign accept         = start && !busy;
  assign accept_compute = accept && (kind == nkc_pkg::KIND_COMPUTE);
  assign empty_kernel   = (kw_eff == '0) || (kh_eff == '0);

  // ---- memories
  nkc_ram #(
    .WIDTH(nkc_pkg::PIXEL_W),
    .DEPTH(nkc_pkg::FRAME_DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (accept && (kind == nkc_pkg::KIND_WRITE_PIXEL)),
    .waddr({row, column}),
    .wdata(pixel_in),
    .raddr({yi, xi}),
    .rdata(frame_rdata)
  );

  nkc_ram #(
    .WIDTH(nkc_pkg::WEIGHT_W),
    .DEPTH(nkc_pkg::WEIGHT_DEPTH)
  ) u_weight (
    .clk  (clk),
    .we   (accept && (kind == nkc_pkg::KIND_LOAD_WEIGHT)),
    .waddr(tap_index),
    .wdata(weight_value),
    .raddr(tap),
    .rdata(weight_rdata)
  );

  // ---- tap walk with edge clamping
  assign ys = base_r + CW'(ki);
  assign xs = base_c + CW'(kj);

  always_comb begin
    priority if (ys < 0) yi = '0;
    else if (ys >= $signed(CW'(h_eff))) yi = nkc_pkg::ROW_W'(h_eff - 1'b1);
    else yi = ys[nkc_pkg::ROW_W-1:0];
    priority if (xs < 0) xi = '0;
    else if (xs >= $signed(CW'(w_eff))) xi = nkc_pkg::COL_W'(w_eff - 1'b1);
    else xi = xs[nkc_pkg::COL_W-1:0];
  end

  assign issue    = (state == nkc_pkg::ST_TAPS);
  assign last_tap = (ki == kh_eff - 1'b1) && (kj == kw_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (accept_compute) begin
      ki      <= '0;
      kj      <= '0;
      tap     <= '0;
      base_r  <= $signed(CW'(row)) - $signed(CW'(kh_eff[nkc_pkg::SIDE_W-1:1]));
      base_c  <= $signed(CW'(column)) - $signed(CW'(kw_eff[nkc_pkg::SIDE_W-1:1]));
      out_row    <= row;
      out_column <= column;
    end else if (issue) begin
      tap <= tap + 1'b1;
      if (kj == kw_eff - 1'b1) begin
        kj <= '0;
        ki <= ki + 1'b1;
      end else begin
        kj <= kj + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  // ---- accumulate
  assign mac_ctrl.clear = accept_compute;
  assign mac_ctrl.valid = rd_valid;

  nkc_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .pixel     (frame_rdata),
    .weight    (weight_rdata),
    .prod_valid(prod_valid),
    .acc       (acc),
    .wsum      (wsum)
  );

  assign pipe_idle = !rd_valid && !prod_valid;

  // ---- normalize
  assign acc_mag   = acc[nkc_pkg::ACC_W-1] ? nkc_pkg::ACC_W'(-acc) : acc;
  assign wsum_mag  = wsum[nkc_pkg::WSUM_W-1] ? nkc_pkg::WSUM_W'(-wsum) : wsum;
  assign wsum_zero = (wsum == '0);
  assign div_start = (state == nkc_pkg::ST_DRAIN) && pipe_idle && !wsum_zero;

  nkc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(acc_mag),
    .divisor (wsum_mag),
    .done    (div_done),
    .quotient(quotient)
  );

  always_comb begin
    pix_load  = 1'b0;
    pix_value = sat_pixel(acc[nkc_pkg::ACC_W-1], acc_mag);
    if (state == nkc_pkg::ST_DRAIN && pipe_idle && wsum_zero) begin
      pix_load = 1'b1;
    end else if (state == nkc_pkg::ST_DIV && div_done) begin
      pix_load  = 1'b1;
      pix_value = sat_pixel(acc[nkc_pkg::ACC_W-1] ^ wsum[nkc_pkg::WSUM_W-1], quotient);
    end
  end

  always_ff @(posedge clk) begin
    if (pix_load) begin
      out_pixel <= pix_value;
    end
  end

  // ---- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nkc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nkc_pkg::ST_IDLE: begin
        if (accept_compute) begin
          state_next = empty_kernel ? nkc_pkg::ST_DRAIN : nkc_pkg::ST_TAPS;
        end
      end
      nkc_pkg::ST_TAPS: begin
        if (last_tap) state_next = nkc_pkg::ST_DRAIN;
      end
      nkc_pkg::ST_DRAIN: begin
        if (pipe_idle) state_next = wsum_zero ? nkc_pkg::ST_OUT : nkc_pkg::ST_DIV;
      end
      nkc_pkg::ST_DIV: begin
        if (div_done) state_next = nkc_pkg::ST_OUT;
      end
      nkc_pkg::ST_OUT: state_next = nkc_pkg::ST_IDLE;
      default: state_next = nkc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy = (state != nkc_pkg::ST_IDLE);
    done = (state == nkc_pkg::ST_OUT);
  end

  // ---- checks
  `NKC_ASSERT_NEXT(a_compute_goes_busy, accept_compute, busy,
    "compute item accepted but block not busy")
  `NKC_ASSERT_NEXT(a_done_one_cycle, done, !done, "done held longer than one cycle")
  `NKC_ASSERT_NOW(a_div_done_in_div, div_done, state == nkc_pkg::ST_DIV,
    "divider finished outside the divide state")
  `NKC_ASSERT_NOW(a_reads_in_walk, rd_valid || prod_valid,
    state == nkc_pkg::ST_TAPS || state == nkc_pkg::ST_DRAIN,
    "tap data in flight outside the tap walk")

endmodule

`default_nettype wire
